// ===== design/rcst_pkg.sv =====
// ----------------------------------------------------------------------------
// Raycaster package
// Shared constants, item types, sequencer states and the map address helper
// for the grid DDA wall raycaster.
// ----------------------------------------------------------------------------
package rcst_pkg;

  // Screen, texture and map geometry.
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int TEX_WIDTH     = 64;
  localparam int TEX_HEIGHT    = 64;
  localparam int MAP_SIZE      = 64;

  localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
  localparam int MAP_BITS  = $clog2(MAP_SIZE);
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  // Map coordinate: room for the start cell from the 6-bit position integer
  // part and one step beyond either edge, plus a sign.
  localparam int MC_W      = ((MAP_BITS > 6) ? MAP_BITS : 6) + 2;

  // Datapath widths.
  localparam int CAM_W = 18;                                 // camera x, Q1.16
  localparam int RAY_W = 22;                                 // ray component
  localparam int SD_W  = 40;                                 // side distances
  localparam int LH_W  = $clog2((SCREEN_HEIGHT << 16) + 1);  // line height
  localparam int CAM_ONE = 65536;

  // Camera x quotient (column << 17) / screen width by reciprocal
  // multiplication. The reciprocal is rounded up with 2 x log2(width) extra
  // bits, which keeps the truncated quotient exact for every column.
  localparam int     CAM_SH    = 2 * $clog2(SCREEN_WIDTH);
  localparam longint CAM_RECIP = ((longint'(1) << (17 + CAM_SH)) + SCREEN_WIDTH - 1) /
                                 SCREEN_WIDTH;
  localparam int     CAM_P_W   = 10 + $clog2(CAM_RECIP + 1);

  // Shared divider.
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = SD_W;

  // Shared multiplier.
  localparam int MA_W = 33;
  localparam int MB_W0 = (LH_W > RAY_W) ? LH_W : RAY_W;
  localparam int MB_W = ((MB_W0 > 17) ? MB_W0 : 17) + 1;
  localparam int MP_W = MA_W + MB_W;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  // Wall faces.
  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [9:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_is_wall;
  } req_t;

  typedef struct packed {
    logic [9:0]  draw_column;
    logic [23:0] wall_distance;
    logic [8:0]  span_top;
    logic [8:0]  span_bottom;
    logic [1:0]  face;
    logic [5:0]  tex_column;
    logic [22:0] tex_step;
    logic [21:0] tex_start;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_RX_MUL,
    ST_RY_MUL,
    ST_RY_DONE,
    ST_DX_START,
    ST_DX_WAIT,
    ST_DY_START,
    ST_DY_WAIT,
    ST_SDX_MUL,
    ST_SDY_MUL,
    ST_SDY_DONE,
    ST_WALK_STEP,
    ST_WALK_TEST,
    ST_LH_START,
    ST_LH_WAIT,
    ST_STEP_START,
    ST_HIT_MUL,
    ST_HIT_DONE,
    ST_STEP_WAIT,
    ST_TPOS_MUL,
    ST_TPOS_DONE
  } state_t;

  // Linear map address of a cell, row major.
  function automatic logic [ADDR_W-1:0] map_addr(input logic [MC_W-1:0] x,
                                                 input logic [MC_W-1:0] y);
    map_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(MAP_SIZE) + ADDR_W'(x));
  endfunction

endpackage

// ===== design/grid_dda_wall_raycaster.sv =====
// ----------------------------------------------------------------------------
// Grid DDA wall raycaster
// Keeps a one-bit wall map and casts one screen column per cast item.
// ----------------------------------------------------------------------------
// Sequencing: a map write item is taken while idle. A cast item keeps busy
//   high through four divider passes and the grid steps; a zero ray
//   component or zero distance skips its pass.
// Throughput: one item at a time; the result strobe comes as busy falls.
// Reset: rst clears the whole map, one cell a cycle, with busy
//   high. Results are strobed for one cycle; the receiver cannot stall.
module grid_dda_wall_raycaster (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rcst_pkg::req_t request,
  output logic           result_valid,
  output rcst_pkg::res_t result,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [21:0]    cfg_data
);

  localparam int ADDR_W  = rcst_pkg::ADDR_W;
  localparam int MC_W    = rcst_pkg::MC_W;
  localparam int RAY_W   = rcst_pkg::RAY_W;
  localparam int CAM_W   = rcst_pkg::CAM_W;
  localparam int CAM_P_W = rcst_pkg::CAM_P_W;
  localparam int SD_W    = rcst_pkg::SD_W;
  localparam int LH_W    = rcst_pkg::LH_W;
  localparam int MA_W    = rcst_pkg::MA_W;
  localparam int MB_W    = rcst_pkg::MB_W;
  localparam int MP_W    = rcst_pkg::MP_W;
  localparam int NW      = rcst_pkg::DIV_NUM_W;
  localparam int DW      = rcst_pkg::DIV_DEN_W;
  localparam int HALF_H  = rcst_pkg::SCREEN_HEIGHT / 2;

  // Camera registers.
  logic [21:0]        pos_x;
  logic [21:0]        pos_y;
  logic signed [18:0] dir_x;
  logic signed [18:0] dir_y;
  logic signed [18:0] plane_x;
  logic signed [18:0] plane_y;

  // Sequencer.
  rcst_pkg::state_t state;
  rcst_pkg::state_t state_next;
  logic [ADDR_W-1:0] clr_cnt;

  // Per-cast working registers.
  logic [9:0]              col;
  logic signed [CAM_W-1:0] cam;
  logic signed [RAY_W-1:0] rx;
  logic signed [RAY_W-1:0] ry;
  logic [31:0]             dx;
  logic [31:0]             dy;
  logic [SD_W-1:0]         sdx;
  logic [SD_W-1:0]         sdy;
  logic signed [MC_W-1:0]  mx;
  logic signed [MC_W-1:0]  my;
  logic                    side;
  logic                    oob;
  logic [SD_W-1:0]         wd;
  logic [LH_W-1:0]         lh;
  logic [15:0]             frac;
  logic [22:0]             tstep;

  // Shared units and map.
  logic                    div_start;
  logic [NW-1:0]           div_num;
  logic [DW-1:0]           div_den;
  logic                    div_busy;
  logic [NW-1:0]           div_quot;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic                    ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic                    ram_rdata;

  // Derived values.
  logic                    accept_write;
  logic                    accept_cast;
  logic                    cell_ok;
  logic                    col_ok;
  logic [CAM_P_W-1:0]      cam_prod;
  logic [RAY_W-1:0]        rx_mag;
  logic [RAY_W-1:0]        ry_mag;
  logic [16:0]             frac_x_dist;
  logic [16:0]             frac_y_dist;
  logic                    x_first;
  logic signed [MC_W-1:0]  mx_step;
  logic signed [MC_W-1:0]  my_step;
  logic [SD_W-1:0]         sdx_step;
  logic [SD_W-1:0]         sdy_step;
  logic                    oob_step;
  logic                    hit;
  logic [LH_W-1:0]         half;
  logic [LH_W-1:0]         half_h;
  logic [LH_W:0]           end_sum;
  logic [LH_W-1:0]         span_top_w;
  logic [LH_W:0]           span_bottom_w;
  logic [LH_W-1:0]         tpos_term;
  logic [31:0]             tex_raw;
  logic [31:0]             tex_col;
  logic                    tex_mirror;
  logic [1:0]              face_w;

  assign busy = (state != rcst_pkg::ST_IDLE);

  rcst_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  rcst_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rcst_ram #(
    .WIDTH (1),
    .DEPTH (rcst_pkg::MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Item decode and small helpers.
  always_comb begin
    cell_ok = (32'(request.cell_x) < rcst_pkg::MAP_SIZE) &&
              (32'(request.cell_y) < rcst_pkg::MAP_SIZE);
    col_ok  = (32'(request.column) < rcst_pkg::SCREEN_WIDTH);
    accept_write = start && (state == rcst_pkg::ST_IDLE) &&
                   (request.operation == rcst_pkg::OP_WRITE);
    accept_cast  = start && (state == rcst_pkg::ST_IDLE) &&
                   (request.operation == rcst_pkg::OP_CAST) && col_ok;
    // Camera x in Q16 is (2 * column << 16) / screen width, taken here as a
    // product with the rounded-up reciprocal of the screen width.
    cam_prod = CAM_P_W'(col) * CAM_P_W'(rcst_pkg::CAM_RECIP);
    rx_mag = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
    ry_mag = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);
    frac_x_dist = rx[RAY_W-1] ? {1'b0, pos_x[15:0]} : 17'(32'd65536 - 32'(pos_x[15:0]));
    frac_y_dist = ry[RAY_W-1] ? {1'b0, pos_y[15:0]} : 17'(32'd65536 - 32'(pos_y[15:0]));
  end

  // One DDA step: advance along the axis whose side distance is smaller,
  // y on a tie.
  always_comb begin
    x_first  = (sdx < sdy);
    mx_step  = mx;
    my_step  = my;
    sdx_step = sdx;
    sdy_step = sdy;
    if (x_first) begin
      sdx_step = sdx + SD_W'(dx);
      mx_step  = rx[RAY_W-1] ? mx - MC_W'(1) : mx + MC_W'(1);
    end else begin
      sdy_step = sdy + SD_W'(dy);
      my_step  = ry[RAY_W-1] ? my - MC_W'(1) : my + MC_W'(1);
    end
    oob_step = (mx_step < 0) || (my_step < 0) ||
               (mx_step >= rcst_pkg::MAP_SIZE) || (my_step >= rcst_pkg::MAP_SIZE);
    hit = oob || ram_rdata;
  end

  // Vertical span, texture start term, face and texture column.
  always_comb begin
    half   = lh >> 1;
    half_h = LH_W'(HALF_H);
    end_sum = {1'b0, half} + {1'b0, half_h};
    if (half >= half_h) begin
      span_top_w = '0;
      tpos_term  = half - half_h;
    end else begin
      span_top_w = half_h - half;
      tpos_term  = '0;
    end
    if (end_sum >= (LH_W + 1)'(rcst_pkg::SCREEN_HEIGHT)) begin
      span_bottom_w = (LH_W + 1)'(rcst_pkg::SCREEN_HEIGHT - 1);
    end else begin
      span_bottom_w = end_sum;
    end
    if (side) begin
      face_w = ry[RAY_W-1] ? rcst_pkg::FACE_NORTH : rcst_pkg::FACE_SOUTH;
    end else begin
      face_w = rx[RAY_W-1] ? rcst_pkg::FACE_WEST : rcst_pkg::FACE_EAST;
    end
    tex_raw    = (32'(frac) * 32'(rcst_pkg::TEX_WIDTH)) >> 16;
    tex_mirror = (!side && !rx[RAY_W-1] && (rx != '0)) || (side && ry[RAY_W-1]);
    tex_col    = tex_mirror ? 32'(rcst_pkg::TEX_WIDTH) - tex_raw - 32'd1 : tex_raw;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rcst_pkg::ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(rcst_pkg::MAP_CELLS - 1)) begin
          state_next = rcst_pkg::ST_IDLE;
        end
      end
      rcst_pkg::ST_IDLE: begin
        if (accept_cast) begin
          state_next = rcst_pkg::ST_CAM;
        end
      end
      rcst_pkg::ST_CAM:     state_next = rcst_pkg::ST_RX_MUL;
      rcst_pkg::ST_RX_MUL:  state_next = rcst_pkg::ST_RY_MUL;
      rcst_pkg::ST_RY_MUL:  state_next = rcst_pkg::ST_RY_DONE;
      rcst_pkg::ST_RY_DONE: state_next = rcst_pkg::ST_DX_START;
      rcst_pkg::ST_DX_START: begin
        state_next = (rx == '0) ? rcst_pkg::ST_DY_START : rcst_pkg::ST_DX_WAIT;
      end
      rcst_pkg::ST_DX_WAIT: begin
        if (!div_busy) begin
          state_next = rcst_pkg::ST_DY_START;
        end
      end
      rcst_pkg::ST_DY_START: begin
        state_next = (ry == '0) ? rcst_pkg::ST_SDX_MUL : rcst_pkg::ST_DY_WAIT;
      end
      rcst_pkg::ST_DY_WAIT: begin
        if (!div_busy) begin
          state_next = rcst_pkg::ST_SDX_MUL;
        end
      end
      rcst_pkg::ST_SDX_MUL:   state_next = rcst_pkg::ST_SDY_MUL;
      rcst_pkg::ST_SDY_MUL:   state_next = rcst_pkg::ST_SDY_DONE;
      rcst_pkg::ST_SDY_DONE:  state_next = rcst_pkg::ST_WALK_STEP;
      rcst_pkg::ST_WALK_STEP: state_next = rcst_pkg::ST_WALK_TEST;
      rcst_pkg::ST_WALK_TEST: begin
        state_next = hit ? rcst_pkg::ST_LH_START : rcst_pkg::ST_WALK_STEP;
      end
      rcst_pkg::ST_LH_START: begin
        state_next = (wd == '0) ? rcst_pkg::ST_STEP_START : rcst_pkg::ST_LH_WAIT;
      end
      rcst_pkg::ST_LH_WAIT: begin
        if (!div_busy) begin
          state_next = rcst_pkg::ST_STEP_START;
        end
      end
      rcst_pkg::ST_STEP_START: state_next = rcst_pkg::ST_HIT_MUL;
      rcst_pkg::ST_HIT_MUL:    state_next = rcst_pkg::ST_HIT_DONE;
      rcst_pkg::ST_HIT_DONE:   state_next = rcst_pkg::ST_STEP_WAIT;
      rcst_pkg::ST_STEP_WAIT: begin
        if (!div_busy) begin
          state_next = rcst_pkg::ST_TPOS_MUL;
        end
      end
      rcst_pkg::ST_TPOS_MUL:  state_next = rcst_pkg::ST_TPOS_DONE;
      rcst_pkg::ST_TPOS_DONE: state_next = rcst_pkg::ST_IDLE;
      default:                state_next = rcst_pkg::ST_IDLE;
    endcase
  end

  // Operands for the shared divider, multiplier and map.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = 1'b0;
    ram_raddr = rcst_pkg::map_addr(mx_step, my_step);
    unique case (state)
      rcst_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      rcst_pkg::ST_IDLE: begin
        if (accept_write && cell_ok) begin
          ram_we    = 1'b1;
          ram_waddr = rcst_pkg::map_addr(MC_W'(request.cell_x), MC_W'(request.cell_y));
          ram_wdata = request.cell_is_wall;
        end
      end
      rcst_pkg::ST_RX_MUL: begin
        mul_a = MA_W'(plane_x);
        mul_b = MB_W'(cam);
      end
      rcst_pkg::ST_RY_MUL: begin
        mul_a = MA_W'(plane_y);
        mul_b = MB_W'(cam);
      end
      rcst_pkg::ST_DX_START: begin
        if (rx != '0) begin
          div_start = 1'b1;
          div_num   = NW'(64'h1_0000_0000);
          div_den   = DW'(rx_mag);
        end
      end
      rcst_pkg::ST_DY_START: begin
        if (ry != '0) begin
          div_start = 1'b1;
          div_num   = NW'(64'h1_0000_0000);
          div_den   = DW'(ry_mag);
        end
      end
      rcst_pkg::ST_SDX_MUL: begin
        mul_a = MA_W'(dx);
        mul_b = MB_W'(frac_x_dist);
      end
      rcst_pkg::ST_SDY_MUL: begin
        mul_a = MA_W'(dy);
        mul_b = MB_W'(frac_y_dist);
      end
      rcst_pkg::ST_LH_START: begin
        if (wd != '0) begin
          div_start = 1'b1;
          div_num   = NW'(rcst_pkg::SCREEN_HEIGHT) << 16;
          div_den   = wd;
        end
      end
      rcst_pkg::ST_STEP_START: begin
        div_start = 1'b1;
        div_num   = NW'(rcst_pkg::TEX_HEIGHT) << 16;
        div_den   = DW'(lh);
      end
      // Only the low 32 product bits matter for the hit fraction.
      rcst_pkg::ST_HIT_MUL: begin
        mul_a = MA_W'(wd[31:0]);
        mul_b = side ? MB_W'(rx) : MB_W'(ry);
      end
      rcst_pkg::ST_TPOS_MUL: begin
        mul_a = MA_W'(tstep);
        mul_b = MB_W'(tpos_term);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rcst_pkg::ST_CLEAR;
      clr_cnt <= '0;
      pos_x   <= 22'd98304;
      pos_y   <= 22'd98304;
      dir_x   <= -19'sd65536;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= 19'sd43253;
    end else begin
      state <= state_next;
      if (state == rcst_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (cfg_write) begin
        unique case (cfg_index)
          rcst_pkg::REG_POS_X:   pos_x   <= cfg_data;
          rcst_pkg::REG_POS_Y:   pos_y   <= cfg_data;
          rcst_pkg::REG_DIR_X:   dir_x   <= cfg_data[18:0];
          rcst_pkg::REG_DIR_Y:   dir_y   <= cfg_data[18:0];
          rcst_pkg::REG_PLANE_X: plane_x <= cfg_data[18:0];
          rcst_pkg::REG_PLANE_Y: plane_y <= cfg_data[18:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == rcst_pkg::ST_TPOS_DONE);
    end
  end

  // Cast datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      rcst_pkg::ST_IDLE: begin
        if (accept_cast) begin
          col <= request.column;
        end
      end
      rcst_pkg::ST_CAM: begin
        cam <= CAM_W'(cam_prod >> rcst_pkg::CAM_SH) - CAM_W'(rcst_pkg::CAM_ONE);
      end
      rcst_pkg::ST_RY_MUL: begin
        rx <= RAY_W'(dir_x) + RAY_W'(mul_p >>> 16);
      end
      rcst_pkg::ST_RY_DONE: begin
        ry <= RAY_W'(dir_y) + RAY_W'(mul_p >>> 16);
      end
      rcst_pkg::ST_DX_START: begin
        if (rx == '0) begin
          dx <= '1;
        end
      end
      rcst_pkg::ST_DX_WAIT: begin
        if (!div_busy) begin
          dx <= div_quot[32] ? 32'hFFFF_FFFF : div_quot[31:0];
        end
      end
      rcst_pkg::ST_DY_START: begin
        if (ry == '0) begin
          dy <= '1;
        end
      end
      rcst_pkg::ST_DY_WAIT: begin
        if (!div_busy) begin
          dy <= div_quot[32] ? 32'hFFFF_FFFF : div_quot[31:0];
        end
      end
      rcst_pkg::ST_SDY_MUL: begin
        sdx <= mul_p[SD_W+15:16];
      end
      rcst_pkg::ST_SDY_DONE: begin
        sdy <= mul_p[SD_W+15:16];
        mx  <= MC_W'(pos_x[21:16]);
        my  <= MC_W'(pos_y[21:16]);
      end
      rcst_pkg::ST_WALK_STEP: begin
        sdx  <= sdx_step;
        sdy  <= sdy_step;
        mx   <= mx_step;
        my   <= my_step;
        side <= !x_first;
        oob  <= oob_step;
      end
      rcst_pkg::ST_WALK_TEST: begin
        if (hit) begin
          wd <= side ? sdy - SD_W'(dy) : sdx - SD_W'(dx);
        end
      end
      rcst_pkg::ST_LH_START: begin
        if (wd == '0) begin
          lh <= LH_W'(rcst_pkg::SCREEN_HEIGHT << 16);
        end
      end
      rcst_pkg::ST_LH_WAIT: begin
        if (!div_busy) begin
          lh <= (div_quot == '0) ? LH_W'(1) : LH_W'(div_quot);
        end
      end
      rcst_pkg::ST_HIT_DONE: begin
        frac <= (side ? pos_x[15:0] : pos_y[15:0]) + mul_p[31:16];
      end
      rcst_pkg::ST_STEP_WAIT: begin
        if (!div_busy) begin
          tstep <= div_quot[22:0];
        end
      end
      rcst_pkg::ST_TPOS_DONE: begin
        result.draw_column   <= 10'(rcst_pkg::SCREEN_WIDTH - int'(col));
        result.wall_distance <= (wd > SD_W'(24'hFF_FFFF)) ? 24'hFF_FFFF : wd[23:0];
        result.span_top      <= 9'(span_top_w);
        result.span_bottom   <= 9'(span_bottom_w);
        result.face          <= face_w;
        result.tex_column    <= 6'(tex_col);
        result.tex_step      <= tstep;
        result.tex_start     <= mul_p[21:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/rcst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcst_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rcst_div.sv =====
// ----------------------------------------------------------------------------
// Shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcst_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rcst_pkg::DIV_NUM_W-1:0]  num,
  input  logic [rcst_pkg::DIV_DEN_W-1:0]  den,
  output logic                            busy,
  output logic [rcst_pkg::DIV_NUM_W-1:0]  quot
);

  localparam int NW    = rcst_pkg::DIV_NUM_W;
  localparam int DW    = rcst_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [NW-1:0]    sh;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem, sh[NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // The shift register holds the numerator bits still to come and collects
  // the quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= CNT_W'(NW - 1);
      rem   <= '0;
      sh    <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh  <= {sh[NW-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  assign quot = sh;

endmodule

// ===== design/rcst_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rcst_mul (
  input  logic                               clk,
  input  logic signed [rcst_pkg::MA_W-1:0]   a,
  input  logic signed [rcst_pkg::MB_W-1:0]   b,
  output logic signed [rcst_pkg::MP_W-1:0]   p
);

  // Product register.
  always_ff @(posedge clk) begin
    p <= rcst_pkg::MP_W'(a) * rcst_pkg::MP_W'(b);
  end

endmodule
